@@ sv/bds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin dosing sequencer package
// Shared types, constants and lane helpers for the sequencer and its control
// step logic.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int BIN_COUNT = 4;
  localparam int IdxW      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int LaneW     = 4;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [LaneW-1:0] lane_t;

  typedef enum logic [3:0] {
    ST_POWER_ON   = 4'd0,
    ST_HOMING     = 4'd1,
    ST_WAIT_START = 4'd2,
    ST_CHECK_BIN  = 4'd3,
    ST_POSITION   = 4'd4,
    ST_OPENING    = 4'd5,
    ST_FILLING    = 4'd6,
    ST_CLOSING    = 4'd7,
    ST_BIN_FINISH = 4'd8,
    ST_BIN_END    = 4'd9,
    ST_END        = 4'd10,
    ST_POWER_OFF  = 4'd11
  } ctrl_state_e;

  typedef struct packed {
    logic  device_running;
    logic  start_cycle;
    logic  count_overflow;
    logic  home_switch;
    lane_t bin_position;
    lane_t gate_open_sense;
    lane_t fill_timeout;
  } in_item_t;

  typedef struct packed {
    logic        step_left;
    logic        step_right;
    lane_t       open_gate;
    lane_t       close_gate;
    lane_t       timer_reset;
    logic        bin_done;
    logic [3:0]  state_code;
    logic        done_res;
  } out_item_t;

  // Drive bits held across ticks.
  typedef struct packed {
    logic  step_left;
    logic  step_right;
    lane_t open_gate;
    lane_t close_gate;
    lane_t timer_reset;
    logic  bin_done;
  } sig_t;

  typedef struct packed {
    ctrl_state_e state;
    idx_t        bin_index;
    sig_t        sig;
  } ctrl_t;

  // Only bins below LaneW have a lane; higher bins read as not set.
  function automatic logic lane_bit(lane_t v, idx_t idx);
    logic [2:0] idx3;
    idx3 = 3'(idx);
    return idx3[2] ? 1'b0 : v[idx3[1:0]];
  endfunction

  function automatic lane_t lane_mask(idx_t idx);
    logic [2:0] idx3;
    idx3 = 3'(idx);
    return idx3[2] ? lane_t'(0) : (lane_t'(1) << idx3[1:0]);
  endfunction

endpackage

@@ sv/bds_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin dosing control step
// Combinational next-state and result logic for one controller tick.
// ----------------------------------------------------------------------------
module bds_ctrl (
  input  bds_pkg::ctrl_t     cur_i,
  input  bds_pkg::in_item_t  item_i,
  input  bds_pkg::lane_t     bin_pattern_i,
  output bds_pkg::ctrl_t     nxt_o,
  output bds_pkg::out_item_t res_o
);

  bds_pkg::lane_t          mask;
  logic [bds_pkg::IdxW:0]  idx_inc;

  assign mask    = bds_pkg::lane_mask(cur_i.bin_index);
  assign idx_inc = {1'b0, cur_i.bin_index} + (bds_pkg::IdxW + 1)'(1);

  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.state)
      bds_pkg::ST_POWER_ON: begin
        nxt_o.state = bds_pkg::ST_HOMING;
      end
      bds_pkg::ST_HOMING: begin
        if (item_i.home_switch) begin
          nxt_o.sig.step_right = 1'b0;
          nxt_o.state          = bds_pkg::ST_WAIT_START;
        end else begin
          nxt_o.sig.step_right = 1'b1;
        end
      end
      bds_pkg::ST_WAIT_START: begin
        if (item_i.start_cycle) begin
          nxt_o.state = bds_pkg::ST_CHECK_BIN;
        end
      end
      bds_pkg::ST_CHECK_BIN: begin
        if (bds_pkg::lane_bit(bin_pattern_i, cur_i.bin_index)) begin
          nxt_o.state = bds_pkg::ST_POSITION;
        end else begin
          nxt_o.state        = bds_pkg::ST_BIN_END;
          nxt_o.sig.bin_done = 1'b1;
        end
      end
      bds_pkg::ST_POSITION: begin
        if (bds_pkg::lane_bit(item_i.bin_position, cur_i.bin_index)) begin
          nxt_o.state         = bds_pkg::ST_OPENING;
          nxt_o.sig.open_gate = cur_i.sig.open_gate | mask;
          nxt_o.sig.step_left = 1'b0;
        end else begin
          nxt_o.sig.step_left = 1'b1;
        end
      end
      bds_pkg::ST_OPENING: begin
        if (bds_pkg::lane_bit(item_i.gate_open_sense, cur_i.bin_index)) begin
          nxt_o.sig.open_gate   = cur_i.sig.open_gate & ~mask;
          nxt_o.sig.timer_reset = cur_i.sig.timer_reset | mask;
          nxt_o.state           = bds_pkg::ST_FILLING;
        end
      end
      bds_pkg::ST_FILLING: begin
        if (bds_pkg::lane_bit(item_i.fill_timeout, cur_i.bin_index)) begin
          nxt_o.sig.timer_reset = cur_i.sig.timer_reset & ~mask;
          nxt_o.sig.close_gate  = cur_i.sig.close_gate | mask;
          nxt_o.state           = bds_pkg::ST_CLOSING;
        end
      end
      bds_pkg::ST_CLOSING: begin
        if (!bds_pkg::lane_bit(item_i.gate_open_sense, cur_i.bin_index)) begin
          nxt_o.sig.close_gate = cur_i.sig.close_gate & ~mask;
          nxt_o.state          = bds_pkg::ST_BIN_FINISH;
        end
      end
      bds_pkg::ST_BIN_FINISH: begin
        nxt_o.state        = bds_pkg::ST_BIN_END;
        nxt_o.sig.bin_done = 1'b1;
      end
      bds_pkg::ST_BIN_END: begin
        if (item_i.count_overflow) begin
          nxt_o.state = bds_pkg::ST_END;
        end else begin
          // The bin index wraps to zero after the last bin.
          if (idx_inc >= (bds_pkg::IdxW + 1)'(bds_pkg::BIN_COUNT)) begin
            nxt_o.bin_index = '0;
          end else begin
            nxt_o.bin_index = idx_inc[bds_pkg::IdxW-1:0];
          end
          nxt_o.state        = bds_pkg::ST_WAIT_START;
          nxt_o.sig.bin_done = 1'b0;
        end
      end
      default: begin
        nxt_o.state = bds_pkg::ST_POWER_OFF;
      end
    endcase
  end

  always_comb begin
    res_o.step_left   = nxt_o.sig.step_left;
    res_o.step_right  = nxt_o.sig.step_right;
    res_o.open_gate   = nxt_o.sig.open_gate;
    res_o.close_gate  = nxt_o.sig.close_gate;
    res_o.timer_reset = nxt_o.sig.timer_reset;
    res_o.bin_done    = nxt_o.sig.bin_done;
    res_o.state_code  = nxt_o.state;
    res_o.done_res    = (nxt_o.state == bds_pkg::ST_POWER_OFF) || !item_i.device_running;
  end

endmodule

@@ sv/bin_dosing_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin dosing sequencer
// Tick-driven controller that homes a container and doses a pattern of bins.
// ----------------------------------------------------------------------------
// Each request is one controller tick of sampled sensor bits and yields one
// result with the drive bits, the state code and the done flag. The block
// takes one request per clock while the output is not stalled. A request is
// held in the input register; the step logic then updates the controller
// state and loads the result register. While a result waits for out_ready_i
// the request behind it stays in the input register and in_ready_o falls.
// The user must write the bin pattern register through cfg_we_i only while
// no request is in flight; the block does not enforce this.
module bin_dosing_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  bds_pkg::lane_t      cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bds_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bds_pkg::out_item_t  out_data_o
);

  bds_pkg::lane_t     bin_pattern_q;
  logic               s1_valid_q;
  bds_pkg::in_item_t  s1_item_q;
  bds_pkg::ctrl_t     ctrl_q, ctrl_d;
  logic               out_valid_q;
  bds_pkg::out_item_t out_data_q, res;
  logic               s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  bds_ctrl u_ctrl (
    .cur_i         (ctrl_q),
    .item_i        (s1_item_q),
    .bin_pattern_i (bin_pattern_q),
    .nxt_o         (ctrl_d),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_pattern_q <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      ctrl_q.state  <= bds_pkg::ST_POWER_ON;
      ctrl_q.bin_index <= '0;
      ctrl_q.sig    <= '0;
    end else begin
      if (cfg_we_i) begin
        bin_pattern_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        ctrl_q      <= ctrl_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ verif/bin_dosing_sequencer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin dosing sequencer testbench
// Drives controller ticks through the request channel, predicts every result
// tick with a local copy of the sequencer state and compares each field.
// ----------------------------------------------------------------------------
module bin_dosing_sequencer_test;

  localparam int StallLimit = 1000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  bds_pkg::lane_t     cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  bds_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  bds_pkg::out_item_t out_data_o;

  bin_dosing_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Local copy of the sequencer state, advanced once per accepted request.
  bds_pkg::ctrl_state_e seq_state    = bds_pkg::ST_POWER_ON;
  bds_pkg::idx_t        seq_bin      = '0;
  bds_pkg::sig_t        drive        = '0;
  bds_pkg::lane_t       dose_pattern = '0;

  bds_pkg::out_item_t   predicted_outputs[$];
  int                   mismatches   = 0;
  int                   req_idle_pct = 0;
  int                   rsp_idle_pct = 0;
  int                   idle_cycles  = 0;

  function automatic bds_pkg::out_item_t dosing_step(bds_pkg::in_item_t t);
    bds_pkg::out_item_t o;
    bds_pkg::lane_t     bin_bit;
    bin_bit = bds_pkg::lane_t'(1) << seq_bin;
    case (seq_state)
      bds_pkg::ST_POWER_ON: begin
        seq_state = bds_pkg::ST_HOMING;
      end
      bds_pkg::ST_HOMING: begin
        if (t.home_switch) begin
          drive.step_right = 1'b0;
          seq_state = bds_pkg::ST_WAIT_START;
        end else begin
          drive.step_right = 1'b1;
        end
      end
      bds_pkg::ST_WAIT_START: begin
        if (t.start_cycle) seq_state = bds_pkg::ST_CHECK_BIN;
      end
      bds_pkg::ST_CHECK_BIN: begin
        if ((dose_pattern & bin_bit) != 0) begin
          seq_state = bds_pkg::ST_POSITION;
        end else begin
          seq_state = bds_pkg::ST_BIN_END;
          drive.bin_done = 1'b1;
        end
      end
      bds_pkg::ST_POSITION: begin
        if ((t.bin_position & bin_bit) != 0) begin
          seq_state = bds_pkg::ST_OPENING;
          drive.open_gate = drive.open_gate | bin_bit;
          drive.step_left = 1'b0;
        end else begin
          drive.step_left = 1'b1;
        end
      end
      bds_pkg::ST_OPENING: begin
        if ((t.gate_open_sense & bin_bit) != 0) begin
          drive.open_gate   = drive.open_gate & ~bin_bit;
          drive.timer_reset = drive.timer_reset | bin_bit;
          seq_state = bds_pkg::ST_FILLING;
        end
      end
      bds_pkg::ST_FILLING: begin
        if ((t.fill_timeout & bin_bit) != 0) begin
          drive.timer_reset = drive.timer_reset & ~bin_bit;
          drive.close_gate  = drive.close_gate | bin_bit;
          seq_state = bds_pkg::ST_CLOSING;
        end
      end
      bds_pkg::ST_CLOSING: begin
        if ((t.gate_open_sense & bin_bit) == 0) begin
          drive.close_gate = drive.close_gate & ~bin_bit;
          seq_state = bds_pkg::ST_BIN_FINISH;
        end
      end
      bds_pkg::ST_BIN_FINISH: begin
        seq_state = bds_pkg::ST_BIN_END;
        drive.bin_done = 1'b1;
      end
      bds_pkg::ST_BIN_END: begin
        if (t.count_overflow) begin
          seq_state = bds_pkg::ST_END;
        end else begin
          seq_bin = (seq_bin == bds_pkg::idx_t'(bds_pkg::BIN_COUNT - 1)) ?
                    '0 : seq_bin + bds_pkg::idx_t'(1);
          seq_state = bds_pkg::ST_WAIT_START;
          drive.bin_done = 1'b0;
        end
      end
      bds_pkg::ST_END: begin
        seq_state = bds_pkg::ST_POWER_OFF;
      end
      default: begin
        seq_state = bds_pkg::ST_POWER_OFF;
      end
    endcase
    o.step_left   = drive.step_left;
    o.step_right  = drive.step_right;
    o.open_gate   = drive.open_gate;
    o.close_gate  = drive.close_gate;
    o.timer_reset = drive.timer_reset;
    o.bin_done    = drive.bin_done;
    o.state_code  = seq_state;
    o.done_res    = (seq_state == bds_pkg::ST_POWER_OFF) || !t.device_running;
    return o;
  endfunction

  function automatic bds_pkg::in_item_t tick(input bit running, input bit start,
                                             input bit ovf, input bit home,
                                             input bds_pkg::lane_t pos,
                                             input bds_pkg::lane_t gate,
                                             input bds_pkg::lane_t tmo);
    bds_pkg::in_item_t t;
    t.device_running  = running;
    t.start_cycle     = start;
    t.count_overflow  = ovf;
    t.home_switch     = home;
    t.bin_position    = pos;
    t.gate_open_sense = gate;
    t.fill_timeout    = tmo;
    return t;
  endfunction

  // Mostly sensor readings that move the current state along, with random
  // content elsewhere; about one tick in ten is plain noise. Overflow at the
  // end of a bin step is held off unless the sequence is meant to end.
  function automatic bds_pkg::in_item_t next_tick(bit allow_end);
    logic [31:0]       r;
    bds_pkg::in_item_t t;
    bds_pkg::lane_t    bin_bit;
    r = $urandom;
    t = r[$bits(bds_pkg::in_item_t)-1:0];
    bin_bit = bds_pkg::lane_t'(1) << seq_bin;
    t.device_running = ($urandom_range(99) < 85);
    if ($urandom_range(99) >= 10) begin
      case (seq_state)
        bds_pkg::ST_HOMING:     t.home_switch = ($urandom_range(99) < 25);
        bds_pkg::ST_WAIT_START: t.start_cycle = ($urandom_range(99) < 40);
        bds_pkg::ST_POSITION: begin
          if ($urandom_range(99) < 30) t.bin_position = t.bin_position | bin_bit;
          else t.bin_position = t.bin_position & ~bin_bit;
        end
        bds_pkg::ST_OPENING: begin
          if ($urandom_range(99) < 40) t.gate_open_sense = t.gate_open_sense | bin_bit;
          else t.gate_open_sense = t.gate_open_sense & ~bin_bit;
        end
        bds_pkg::ST_FILLING: begin
          if ($urandom_range(99) < 30) t.fill_timeout = t.fill_timeout | bin_bit;
          else t.fill_timeout = t.fill_timeout & ~bin_bit;
        end
        bds_pkg::ST_CLOSING: begin
          if ($urandom_range(99) < 40) t.gate_open_sense = t.gate_open_sense & ~bin_bit;
          else t.gate_open_sense = t.gate_open_sense | bin_bit;
        end
        default: ;
      endcase
    end
    if (seq_state == bds_pkg::ST_BIN_END) t.count_overflow = allow_end;
    return t;
  endfunction

  // Valid is left high on return so that a following request can go out
  // back to back; whoever stops sending lowers it.
  task automatic send_tick(bds_pkg::in_item_t t);
    while ($urandom_range(99) < req_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_outputs.push_back(dosing_step(t));
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pattern(bds_pkg::lane_t p);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dose_pattern = p;
  endtask

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    bds_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_outputs.size() == 0) begin
        $error("result tick arrived with no request pending");
        mismatches++;
      end else begin
        want = predicted_outputs.pop_front();
        check_field("step_left", 4'(want.step_left), 4'(out_data_o.step_left));
        check_field("step_right", 4'(want.step_right), 4'(out_data_o.step_right));
        check_field("open_gate", want.open_gate, out_data_o.open_gate);
        check_field("close_gate", want.close_gate, out_data_o.close_gate);
        check_field("timer_reset", want.timer_reset, out_data_o.timer_reset);
        check_field("bin_done", 4'(want.bin_done), 4'(out_data_o.bin_done));
        check_field("state_code", want.state_code, out_data_o.state_code);
        check_field("done_res", 4'(want.done_res), 4'(out_data_o.done_res));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= rsp_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("bin_dosing_sequencer_test failed");
      $finish;
    end
  end

  // Homing, then four skipped bins so the bin index wraps back to zero.
  task automatic test_homing_and_bin_skip();
    int i;
    write_pattern(4'h0);
    send_tick(tick(1, 1, 1, 1, 4'hF, 4'hF, 4'hF));
    send_tick(tick(0, 0, 0, 0, 4'h0, 4'h0, 4'h0));
    send_tick(tick(1, 1, 1, 0, 4'hF, 4'hF, 4'hF));
    send_tick(tick(1, 0, 0, 1, 4'h0, 4'h0, 4'h0));
    for (i = 0; i < bds_pkg::BIN_COUNT; i++) begin
      send_tick(tick(1, 1, 0, 0, 4'h0, 4'h0, 4'h0));
      send_tick(tick(1, 0, 1, 1, 4'hF, 4'hF, 4'hF));
      send_tick(tick(1, 1, 0, 1, 4'hF, 4'hF, 4'hF));
    end
  endtask

  // One full fill of bin 0, with sensor hits on the other bins only first.
  task automatic test_bin_fill();
    wait_for_drain();
    write_pattern(4'hF);
    send_tick(tick(1, 1, 0, 0, 4'h0, 4'h0, 4'h0));
    send_tick(tick(1, 0, 1, 0, 4'hF, 4'hF, 4'hF));
    send_tick(tick(1, 0, 0, 0, 4'b1110, 4'h0, 4'h0));
    send_tick(tick(0, 0, 0, 0, 4'b0001, 4'h0, 4'h0));
    send_tick(tick(1, 0, 0, 0, 4'h0, 4'b1110, 4'h0));
    send_tick(tick(1, 0, 0, 0, 4'h0, 4'b0001, 4'h0));
    send_tick(tick(1, 0, 0, 0, 4'hF, 4'hF, 4'b1110));
    send_tick(tick(1, 0, 0, 0, 4'h0, 4'hF, 4'hF));
    send_tick(tick(1, 0, 0, 0, 4'h0, 4'b0001, 4'h0));
    send_tick(tick(1, 0, 0, 0, 4'h0, 4'b1110, 4'h0));
    send_tick(tick(1, 0, 0, 0, 4'h0, 4'h0, 4'h0));
    send_tick(tick(1, 0, 0, 0, 4'h0, 4'h0, 4'h0));
  endtask

  task automatic run_random_ticks(int count, bit hold_for_drain);
    int i;
    wait_for_drain();
    write_pattern(bds_pkg::lane_t'($urandom_range(1, 14)));
    for (i = 0; i < count; i++) begin
      if (hold_for_drain && i == count / 2) wait_for_drain();
      send_tick(next_tick(1'b0));
    end
  endtask

  task automatic test_random_slow_receiver();
    req_idle_pct = 37;
    rsp_idle_pct = 60;
    run_random_ticks(520, 1'b1);
  endtask

  task automatic test_random_slow_sender();
    req_idle_pct = 60;
    rsp_idle_pct = 37;
    run_random_ticks(520, 1'b0);
  endtask

  task automatic test_random_full_rate();
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    run_random_ticks(520, 1'b0);
  endtask

  // Power off is sticky, so this runs last: overflow ends the sequence and
  // the remaining requests must all report power off.
  task automatic test_overflow_end();
    int i;
    wait_for_drain();
    req_idle_pct = 20;
    rsp_idle_pct = 20;
    write_pattern(bds_pkg::lane_t'($urandom_range(0, 15)));
    while (seq_state != bds_pkg::ST_POWER_OFF) send_tick(next_tick(1'b1));
    send_tick(tick(1, 1, 1, 1, 4'hF, 4'hF, 4'hF));
    send_tick(tick(0, 0, 0, 0, 4'h0, 4'h0, 4'h0));
    for (i = 0; i < 10; i++) send_tick(next_tick(1'b1));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    req_idle_pct = 20;
    rsp_idle_pct = 20;
    test_homing_and_bin_skip();
    test_bin_fill();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();
    test_overflow_end();
    wait_for_drain();
    if (mismatches == 0) begin
      $display("bin_dosing_sequencer_test passed");
    end else begin
      $display("bin_dosing_sequencer_test failed");
    end
    $finish;
  end

endmodule
